// ===== design/dpmc_pkg.sv =====
// shared types, constants and helpers for the distorted projection mask cost block
package dpmc_pkg;

    localparam int DEF_MASK_DEPTH       = 262144;
    localparam int DEF_MAX_BOARD_POINTS = 1048575;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam int COST_W = 18;
    localparam logic [COST_W-1:0] OUTSIDE_COST = 18'd160000;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = 64;

    localparam int DIV_W   = 58;
    localparam int QUOT_W  = 23;
    localparam int STEP_W  = 5;
    localparam logic [STEP_W-1:0] DIV_STEPS_PROJ = 5'd23;
    localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = 5'd18;

    localparam logic signed [63:0] GAIN_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] GAIN_MIN = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] GAIN_ONE = 64'sh0000_0000_0010_0000;

    typedef enum logic [2:0] {
        CFG_ROT_X,
        CFG_ROT_Y,
        CFG_ROT_Z,
        CFG_TRANS,
        CFG_RADIAL,
        CFG_TANG,
        CFG_INTR,
        CFG_GEOM
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAM,
        ST_DIVX,
        ST_DIVY,
        ST_POLY,
        ST_FIN,
        ST_MEAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               func;
        logic [17:0]        mask_address;
        logic [15:0]        mask_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               board_last;
    } t_in_item;

    typedef struct packed {
        logic [COST_W-1:0] cost_value;
        logic              outside_image;
        logic              board_mean;
    } t_out_item;

    typedef struct packed {
        logic [62:0] rot_x;
        logic [62:0] rot_y;
        logic [62:0] rot_z;
        logic [62:0] trans;
        logic [62:0] radial;
        logic [41:0] tang;
        logic [63:0] intr;
        logic [32:0] geom;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // one signed 21-bit subfield of a packed register
    function automatic logic signed [20:0] sub21(input logic [62:0] w, input logic [1:0] idx);
        return w[idx*21 +: 21];
    endfunction

endpackage

// ===== design/dpmc_cfg.sv =====
// apb register bank holding pose, distortion, intrinsics and geometry
module dpmc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpmc_pkg::APB_AW-1:0]  paddr,
    input  logic [dpmc_pkg::APB_DW-1:0]  pwdata,
    output logic [dpmc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output dpmc_pkg::t_cfg               o_cfg
);
    import dpmc_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx idx;

    assign idx    = t_cfg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                CFG_ROT_X:  r_cfg.rot_x  <= pwdata[62:0];
                CFG_ROT_Y:  r_cfg.rot_y  <= pwdata[62:0];
                CFG_ROT_Z:  r_cfg.rot_z  <= pwdata[62:0];
                CFG_TRANS:  r_cfg.trans  <= pwdata[62:0];
                CFG_RADIAL: r_cfg.radial <= pwdata[62:0];
                CFG_TANG:   r_cfg.tang   <= pwdata[41:0];
                CFG_INTR:   r_cfg.intr   <= pwdata;
                CFG_GEOM:   r_cfg.geom   <= pwdata[32:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_ROT_X:  prdata = APB_DW'(r_cfg.rot_x);
            CFG_ROT_Y:  prdata = APB_DW'(r_cfg.rot_y);
            CFG_ROT_Z:  prdata = APB_DW'(r_cfg.rot_z);
            CFG_TRANS:  prdata = APB_DW'(r_cfg.trans);
            CFG_RADIAL: prdata = APB_DW'(r_cfg.radial);
            CFG_TANG:   prdata = APB_DW'(r_cfg.tang);
            CFG_INTR:   prdata = r_cfg.intr;
            CFG_GEOM:   prdata = APB_DW'(r_cfg.geom);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== design/dpmc_mul.sv =====
// shared signed multiplier with registered product
module dpmc_mul (
    input  logic                                 i_clk,
    input  logic signed [dpmc_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [dpmc_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [dpmc_pkg::PROD_W-1:0]   o_prod
);
    import dpmc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/dpmc_div.sv =====
// shared restoring divider, one quotient bit per cycle
module dpmc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dpmc_pkg::t_div_req           i_req,
    input  logic [dpmc_pkg::DIV_W-1:0]   i_num,
    input  logic [dpmc_pkg::DIV_W-1:0]   i_den,
    output dpmc_pkg::t_div_rsp           o_rsp
);
    import dpmc_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic              r_ovf;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_q;
    logic [DIV_W-1:0]  rem_x2;
    logic              fits;
    logic              start_ovf;

    assign rem_x2    = {r_rem[DIV_W-2:0], 1'b0};
    assign fits      = rem_x2 >= r_den;
    assign start_ovf = i_num >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= start_ovf ? '0 : i_req.steps;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= start_ovf;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= fits ? rem_x2 - r_den : rem_x2;
            r_q   <= {r_q[QUOT_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_q;

endmodule

// ===== design/dpmc_mem.sv =====
// distance transform word store, one write and one registered read port
module dpmc_mem #(
    parameter int DEPTH = dpmc_pkg::DEF_MASK_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/distorted_projection_mask_cost_core.sv =====
// top level: sequencer around the shared multiplier, divider and mask store
// A mask item writes one distance-transform word if its address lies within the store. A
// point item is transformed by the configured pose, divided by depth, distorted with three
// radial and two tangential terms, mapped through the intrinsics and used to read the
// column-major mask; points outside the image, with non-positive depth or with a normalized
// coordinate of magnitude 8 or more cost 160000 (10000.0 in Q14.4). The block works on one
// item at a time and drops ready while busy. A point passes through its accept step, 11
// steps of the shared multiplier for the pose, two 23-step divisions on the shared restoring
// divider, 20 multiplier steps for distortion, intrinsics and the store address, the
// registered mask read and the load of the output register. Points that fail early finish
// sooner. In board-mean mode a point that closes its board adds the 18-step mean division.
// Results sit in an output register, so a waiting result does not stop the next item from
// being accepted.
module distorted_projection_mask_cost_core #(
    parameter int MASK_DEPTH       = dpmc_pkg::DEF_MASK_DEPTH,
    parameter int MAX_BOARD_POINTS = dpmc_pkg::DEF_MAX_BOARD_POINTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  dpmc_pkg::t_in_item           i_in_data,
    // item output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output dpmc_pkg::t_out_item          o_out_data,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpmc_pkg::APB_AW-1:0]  paddr,
    input  logic [dpmc_pkg::APB_DW-1:0]  pwdata,
    output logic [dpmc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import dpmc_pkg::*;

    localparam int AW = $clog2(MASK_DEPTH);
    localparam int CW = $clog2(MAX_BOARD_POINTS + 1);
    localparam int SW = CW + COST_W;

    // control state
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [SW-1:0]     r_board_sum, n_board_sum;
    logic [CW-1:0]     r_board_count, n_board_count;
    logic              r_board_seen, n_board_seen;

    // item payload and intermediate values
    logic signed [31:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic               r_last, n_last;
    logic signed [63:0] r_acc, n_acc;
    logic signed [53:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic signed [23:0] r_x, n_x, r_y, n_y;
    logic signed [27:0] r_r2, n_r2;
    logic signed [34:0] r_r4, n_r4;
    logic signed [41:0] r_r6, n_r6;
    logic signed [31:0] r_a, n_a;
    logic signed [26:0] r_xy, n_xy, r_xs, n_xs, r_ys, n_ys;
    logic signed [35:0] r_xd, n_xd, r_yd, n_yd;
    logic signed [63:0] r_u, n_u, r_v, n_v;
    logic               r_outside, n_outside;
    logic [COST_W-1:0]  r_cost, n_cost;
    logic               r_is_mean, n_is_mean;
    t_out_item          r_out, n_out;

    // shared units
    t_cfg                       cfg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;
    logic [DIV_W-1:0]           div_num;
    logic [DIV_W-1:0]           div_den;
    logic [15:0]                mem_rdata;
    logic                       mem_we;

    // helpers
    logic                      in_acc;
    logic [DIV_W-1:0]          cx_abs, cy_abs, cz_den;
    logic signed [63:0]        poly_sum, gain_full;
    logic signed [31:0]        gain_sat;
    logic [63:0]               mem_addr_full;
    logic                      uv_outside;
    logic [COST_W-1:0]         fin_cost;
    logic [15:0]               img_w, img_h;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign img_w      = cfg.geom[15:0];
    assign img_h      = cfg.geom[31:16];

    // depth division operates on magnitudes, divisor scaled so the quotient stays below 8
    assign cx_abs = DIV_W'(r_cx[53] ? -r_cx : r_cx);
    assign cy_abs = DIV_W'(r_cy[53] ? -r_cy : r_cy);
    assign cz_den = DIV_W'(r_cz) << 3;

    // radial gain, k3 term arrives split into high and low halves of r6
    assign poly_sum  = r_acc + (prod <<< 21);
    assign gain_full = GAIN_ONE + (poly_sum >>> 16);
    always_comb begin
        if (gain_full > GAIN_MAX) begin
            gain_sat = GAIN_MAX[31:0];
        end else if (gain_full < GAIN_MIN) begin
            gain_sat = GAIN_MIN[31:0];
        end else begin
            gain_sat = gain_full[31:0];
        end
    end

    assign uv_outside = r_u[63] || r_v[63]
                     || (r_u >= 64'({img_w, 24'd0}))
                     || (r_v >= 64'({img_h, 24'd0}));
    assign mem_addr_full = prod + 64'(r_v[39:24]);
    assign fin_cost = r_outside ? OUTSIDE_COST : COST_W'(mem_rdata);
    assign mem_we   = in_acc && !i_in_data.func
                   && (32'(i_in_data.mask_address) < 32'(MASK_DEPTH));

    dpmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dpmc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    dpmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp)
    );

    dpmc_mem #(
        .DEPTH (MASK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_in_data.mask_address)),
        .i_wdata (i_in_data.mask_value),
        .i_raddr (AW'(mem_addr_full)),
        .o_rdata (mem_rdata)
    );

    // sequencer: each step issues at most one multiply and retires the product of the step before
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_board_sum   = r_board_sum;
        n_board_count = r_board_count;
        n_board_seen  = r_board_seen;
        n_px = r_px;  n_py = r_py;  n_pz = r_pz;  n_last = r_last;
        n_acc = r_acc;
        n_cx = r_cx;  n_cy = r_cy;  n_cz = r_cz;
        n_x = r_x;    n_y = r_y;
        n_r2 = r_r2;  n_r4 = r_r4;  n_r6 = r_r6;  n_a = r_a;
        n_xy = r_xy;  n_xs = r_xs;  n_ys = r_ys;
        n_xd = r_xd;  n_yd = r_yd;  n_u = r_u;    n_v = r_v;
        n_outside = r_outside;
        n_cost    = r_cost;
        n_is_mean = r_is_mean;
        n_out     = r_out;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        div_num = cx_abs;
        div_den = cz_den;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.func) begin
                    n_px      = i_in_data.point_x;
                    n_py      = i_in_data.point_y;
                    n_pz      = i_in_data.point_z;
                    n_last    = i_in_data.board_last;
                    n_outside = 1'b0;
                    n_step    = '0;
                    n_state   = ST_CAM;
                end
            end

            // rigid pose: three dot products plus translation, exact with 35 fraction bits
            ST_CAM: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    5'd0: begin mul_a = 36'(r_px); mul_b = 28'(sub21(cfg.rot_x, 2'd0)); end
                    5'd1: begin mul_a = 36'(r_py); mul_b = 28'(sub21(cfg.rot_x, 2'd1)); end
                    5'd2: begin mul_a = 36'(r_pz); mul_b = 28'(sub21(cfg.rot_x, 2'd2)); end
                    5'd3: begin mul_a = 36'(r_px); mul_b = 28'(sub21(cfg.rot_y, 2'd0)); end
                    5'd4: begin mul_a = 36'(r_py); mul_b = 28'(sub21(cfg.rot_y, 2'd1)); end
                    5'd5: begin mul_a = 36'(r_pz); mul_b = 28'(sub21(cfg.rot_y, 2'd2)); end
                    5'd6: begin mul_a = 36'(r_px); mul_b = 28'(sub21(cfg.rot_z, 2'd0)); end
                    5'd7: begin mul_a = 36'(r_py); mul_b = 28'(sub21(cfg.rot_z, 2'd1)); end
                    5'd8: begin mul_a = 36'(r_pz); mul_b = 28'(sub21(cfg.rot_z, 2'd2)); end
                    default: ;
                endcase
                case (r_step)
                    5'd1: n_acc = (64'(sub21(cfg.trans, 2'd0)) <<< 25) + prod;
                    5'd4: n_acc = (64'(sub21(cfg.trans, 2'd1)) <<< 25) + prod;
                    5'd7: n_acc = (64'(sub21(cfg.trans, 2'd2)) <<< 25) + prod;
                    5'd2, 5'd5, 5'd8: n_acc = r_acc + prod;
                    5'd3: n_cx = 54'(r_acc + prod);
                    5'd6: n_cy = 54'(r_acc + prod);
                    5'd9: n_cz = 54'(r_acc + prod);
                    default: ;
                endcase
                if (r_step == 5'd10) begin
                    if (r_cz[53] || r_cz == '0) begin
                        // point behind or on the camera plane
                        n_outside = 1'b1;
                        n_state   = ST_FIN;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.steps = DIV_STEPS_PROJ;
                        n_state       = ST_DIVX;
                    end
                end
            end

            ST_DIVX: begin
                div_num = cy_abs;
                if (div_rsp.done) begin
                    if (div_rsp.ovf) begin
                        n_outside = 1'b1;
                        n_state   = ST_FIN;
                    end else begin
                        n_x = r_cx[53] ? -24'(div_rsp.quot) : 24'(div_rsp.quot);
                        div_req.start = 1'b1;
                        div_req.steps = DIV_STEPS_PROJ;
                        n_state       = ST_DIVY;
                    end
                end
            end

            ST_DIVY: begin
                if (div_rsp.done) begin
                    if (div_rsp.ovf) begin
                        n_outside = 1'b1;
                        n_state   = ST_FIN;
                    end else begin
                        n_y     = r_cy[53] ? -24'(div_rsp.quot) : 24'(div_rsp.quot);
                        n_step  = '0;
                        n_state = ST_POLY;
                    end
                end
            end

            // distortion, intrinsics and store address
            ST_POLY: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    5'd0:  begin mul_a = 36'(r_x);  mul_b = 28'(r_x); end
                    5'd1:  begin mul_a = 36'(r_y);  mul_b = 28'(r_y); end
                    5'd2:  begin mul_a = 36'(r_x);  mul_b = 28'(r_y); end
                    5'd3:  begin mul_a = 36'(r_r2); mul_b = r_r2; end
                    5'd4:  begin mul_a = 36'(r_r2); mul_b = 28'(sub21(cfg.radial, 2'd0)); end
                    5'd5:  begin mul_a = 36'(r_r4); mul_b = r_r2; end
                    5'd6:  begin mul_a = 36'(r_r4); mul_b = 28'(sub21(cfg.radial, 2'd1)); end
                    5'd7:  begin
                        mul_a = 36'({1'b0, r_r6[20:0]});
                        mul_b = 28'(sub21(cfg.radial, 2'd2));
                    end
                    5'd8:  begin
                        mul_a = 36'(r_r6 >>> 21);
                        mul_b = 28'(sub21(cfg.radial, 2'd2));
                    end
                    5'd9:  begin mul_a = 36'(r_xy); mul_b = 28'(sub21(63'(cfg.tang), 2'd0)); end
                    5'd10: begin
                        mul_a = 36'(r_r2) + (36'(r_xs) <<< 1);
                        mul_b = 28'(sub21(63'(cfg.tang), 2'd1));
                    end
                    5'd11: begin mul_a = 36'(r_a);  mul_b = 28'(r_x); end
                    5'd12: begin
                        mul_a = 36'(r_r2) + (36'(r_ys) <<< 1);
                        mul_b = 28'(sub21(63'(cfg.tang), 2'd0));
                    end
                    5'd13: begin mul_a = 36'(r_xy); mul_b = 28'(sub21(63'(cfg.tang), 2'd1)); end
                    5'd14: begin mul_a = 36'(r_a);  mul_b = 28'(r_y); end
                    5'd15: begin mul_a = r_xd; mul_b = 28'(cfg.intr[15:0]); end
                    5'd16: begin mul_a = r_yd; mul_b = 28'(cfg.intr[31:16]); end
                    5'd18: begin mul_a = 36'(r_u[39:24]); mul_b = 28'(img_h); end
                    default: ;
                endcase
                case (r_step)
                    5'd1:  begin n_xs = 27'(prod >>> 20); n_acc = prod; end
                    5'd2:  begin
                        n_ys = 27'(prod >>> 20);
                        n_r2 = 28'((r_acc + prod) >>> 20);
                    end
                    5'd3:  n_xy = 27'(prod >>> 20);
                    5'd4:  n_r4 = 35'(prod >>> 20);
                    5'd5:  n_acc = prod;
                    5'd6:  n_r6 = 42'(prod >>> 20);
                    5'd7, 5'd8: n_acc = r_acc + prod;
                    5'd9:  n_a = gain_sat;
                    5'd10: n_acc = prod <<< 1;
                    5'd11: n_acc = r_acc + prod;
                    5'd12: n_xd = 36'((prod >>> 20) + (r_acc >>> 16));
                    5'd13: n_acc = prod;
                    5'd14: n_acc = r_acc + (prod <<< 1);
                    5'd15: n_yd = 36'((prod >>> 20) + (r_acc >>> 16));
                    5'd16: n_u = prod + 64'({cfg.intr[47:32], 20'd0});
                    5'd17: n_v = prod + 64'({cfg.intr[63:48], 20'd0});
                    default: ;
                endcase
                if (r_step == 5'd18 && uv_outside) begin
                    n_outside = 1'b1;
                    n_state   = ST_FIN;
                end
                if (r_step == 5'd19) begin
                    // store read is registered this edge
                    if (mem_addr_full >= 64'(MASK_DEPTH)) begin
                        n_outside = 1'b1;
                    end
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!cfg.geom[32]) begin
                    n_cost    = fin_cost;
                    n_is_mean = 1'b0;
                    n_state   = ST_OUT;
                end else begin
                    // a full board keeps its sum and count but still tracks outside points
                    if (r_board_count < CW'(MAX_BOARD_POINTS)) begin
                        n_board_sum   = r_board_sum + SW'(fin_cost);
                        n_board_count = r_board_count + 1'b1;
                    end
                    if (r_outside) begin
                        n_board_seen = 1'b1;
                    end
                    if (r_last) begin
                        n_step  = '0;
                        n_state = ST_MEAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            // mean is below 2^18, so the divisor is the count shifted up by 18
            ST_MEAN: begin
                div_num = DIV_W'(r_board_sum);
                div_den = DIV_W'(r_board_count) << COST_W;
                if (r_step == '0) begin
                    div_req.start = 1'b1;
                    div_req.steps = DIV_STEPS_MEAN;
                    n_step        = 5'd1;
                end else if (div_rsp.done) begin
                    n_cost        = div_rsp.quot[COST_W-1:0];
                    n_outside     = r_board_seen;
                    n_is_mean     = 1'b1;
                    n_board_sum   = '0;
                    n_board_count = '0;
                    n_board_seen  = 1'b0;
                    n_state       = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.cost_value    = r_cost;
                    n_out.outside_image = r_outside;
                    n_out.board_mean    = r_is_mean;
                    n_state             = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
            r_board_sum   <= '0;
            r_board_count <= '0;
            r_board_seen  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_step        <= n_step;
            r_out_valid   <= n_out_valid;
            r_board_sum   <= n_board_sum;
            r_board_count <= n_board_count;
            r_board_seen  <= n_board_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;  r_py <= n_py;  r_pz <= n_pz;  r_last <= n_last;
        r_acc <= n_acc;
        r_cx <= n_cx;  r_cy <= n_cy;  r_cz <= n_cz;
        r_x <= n_x;    r_y <= n_y;
        r_r2 <= n_r2;  r_r4 <= n_r4;  r_r6 <= n_r6;  r_a <= n_a;
        r_xy <= n_xy;  r_xs <= n_xs;  r_ys <= n_ys;
        r_xd <= n_xd;  r_yd <= n_yd;  r_u <= n_u;    r_v <= n_v;
        r_outside <= n_outside;
        r_cost    <= n_cost;
        r_is_mean <= n_is_mean;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a point item keeps the block busy on the next cycle
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.func |=> !o_in_ready)
        else $error("ready after point item accepted");

    // new results only come out of the output load step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("output valid rose outside the load step");

    // the board counter saturates at its limit
    a_board_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_board_count <= CW'(MAX_BOARD_POINTS))
        else $error("board count past limit");

    // divider completions only arrive while a division is awaited
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIVX || r_state == ST_DIVY || r_state == ST_MEAN))
        else $error("divider done in unexpected state");

    // a mean result always closes the board
    a_mean_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MEAN && div_rsp.done |=> r_board_count == '0 && !r_board_seen)
        else $error("board not cleared after mean");

endmodule

// ===== verif/dpmc_cost_checker.sv =====
// cost checker: watches the register port and both item channels, predicts and compares
`timescale 1ns / 100ps
module dpmc_cost_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  dpmc_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  dpmc_pkg::t_out_item           i_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [dpmc_pkg::APB_AW-1:0]   paddr,
    input  logic [dpmc_pkg::APB_DW-1:0]   pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    localparam longint STORE_DEPTH = dpmc_pkg::DEF_MASK_DEPTH;
    localparam longint BOARD_LIMIT = dpmc_pkg::DEF_MAX_BOARD_POINTS;

    logic [63:0]         cfg_shadow [8];
    logic [15:0]         mask_words [0:dpmc_pkg::DEF_MASK_DEPTH-1];
    longint              board_total;
    longint              board_points;
    bit                  board_missed;
    dpmc_pkg::t_out_item expected_costs [$];

    // signed 21-bit subfield
    function automatic longint field21(input logic [63:0] w, input int pos);
        logic signed [20:0] f;
        longint             r;
        f = w[pos +: 21];
        r = f;
        return r;
    endfunction

    // depth division, Q.20 truncated toward zero; fails at magnitude 8
    function automatic bit depth_divide(input longint num, input longint den,
                                        output longint quo);
        longint unsigned mag, dv, q, r;
        mag = (num < 0) ? -num : num;
        dv  = den;
        q   = mag / dv;
        r   = mag % dv;
        quo = 0;
        if (q >= 8) return 1'b0;
        for (int i = 0; i < 20; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= dv) begin
                r = r - dv;
                q = q | 1;
            end
        end
        quo = (num < 0) ? -longint'(q) : longint'(q);
        return 1'b1;
    endfunction

    function automatic longint cam_axis(input int row, input int tpos, input longint px,
                                        input longint py, input longint pz);
        return field21(cfg_shadow[row], 0) * px + field21(cfg_shadow[row], 21) * py
             + field21(cfg_shadow[row], 42) * pz
             + field21(cfg_shadow[dpmc_pkg::CFG_TRANS], tpos) * 64'sd33554432;
    endfunction

    // projects one point; returns 1 when it lands inside with its mask word
    function automatic bit project_cost(input dpmc_pkg::t_in_item it, output logic [15:0] word);
        longint px, py, pz, cx3, cy3, cz3, x, y, r2, r4, r6, gain, xy, xs, ys, xd, yd, u, v;
        longint k1, k2, k3, p1, p2, fx, fy, ox, oy, w, h, col, row, addr;
        logic [63:0] intr, geom;
        word = '0;
        px   = longint'(it.point_x);
        py   = longint'(it.point_y);
        pz   = longint'(it.point_z);
        cx3  = cam_axis(dpmc_pkg::CFG_ROT_X, 0, px, py, pz);
        cy3  = cam_axis(dpmc_pkg::CFG_ROT_Y, 21, px, py, pz);
        cz3  = cam_axis(dpmc_pkg::CFG_ROT_Z, 42, px, py, pz);
        if (cz3 <= 0) return 1'b0;
        if (!depth_divide(cx3, cz3, x)) return 1'b0;
        if (!depth_divide(cy3, cz3, y)) return 1'b0;
        k1   = field21(cfg_shadow[dpmc_pkg::CFG_RADIAL], 0);
        k2   = field21(cfg_shadow[dpmc_pkg::CFG_RADIAL], 21);
        k3   = field21(cfg_shadow[dpmc_pkg::CFG_RADIAL], 42);
        p1   = field21(cfg_shadow[dpmc_pkg::CFG_TANG], 0);
        p2   = field21(cfg_shadow[dpmc_pkg::CFG_TANG], 21);
        intr = cfg_shadow[dpmc_pkg::CFG_INTR];
        geom = cfg_shadow[dpmc_pkg::CFG_GEOM];
        fx   = longint'(intr[15:0]);
        fy   = longint'(intr[31:16]);
        ox   = longint'(intr[47:32]);
        oy   = longint'(intr[63:48]);
        w    = longint'(geom[15:0]);
        h    = longint'(geom[31:16]);
        r2   = (x * x + y * y) >>> 20;
        r4   = (r2 * r2) >>> 20;
        r6   = (r4 * r2) >>> 20;
        gain = 64'sd1048576 + ((k1 * r2 + k2 * r4 + k3 * r6) >>> 16);
        if (gain > 64'sd2147483647) gain = 64'sd2147483647;
        if (gain < -64'sd2147483648) gain = -64'sd2147483648;
        xy   = (x * y) >>> 20;
        xs   = (x * x) >>> 20;
        ys   = (y * y) >>> 20;
        xd   = ((gain * x) >>> 20) + ((2 * p1 * xy + p2 * (r2 + 2 * xs)) >>> 16);
        yd   = ((gain * y) >>> 20) + ((p1 * (r2 + 2 * ys) + 2 * p2 * xy) >>> 16);
        u    = fx * xd + ox * 64'sd1048576;
        v    = fy * yd + oy * 64'sd1048576;
        if (u < 0 || v < 0) return 1'b0;
        if (u >= (w <<< 24) || v >= (h <<< 24)) return 1'b0;
        col  = u >>> 24;
        row  = v >>> 24;
        addr = col * h + row;
        if (addr >= STORE_DEPTH) return 1'b0;
        word = mask_words[addr];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        dpmc_pkg::t_out_item exp_item;
        logic [15:0]         word;
        logic [17:0]         cost;
        bit                  landed;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) cfg_shadow[i] = '0;
            board_total  = 0;
            board_points = 0;
            board_missed = 0;
            expected_costs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (dpmc_pkg::t_cfg_idx'(paddr[5:3]))
                    dpmc_pkg::CFG_TANG: cfg_shadow[paddr[5:3]] = pwdata & 64'h3FF_FFFF_FFFF;
                    dpmc_pkg::CFG_INTR: cfg_shadow[paddr[5:3]] = pwdata;
                    dpmc_pkg::CFG_GEOM: cfg_shadow[paddr[5:3]] = pwdata & 64'h1_FFFF_FFFF;
                    default:            cfg_shadow[paddr[5:3]] = pwdata & 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            // results first: an item accepted now cannot have its result out at this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_costs.size() == 0) begin
                    report_mismatch("unexpected result, cost", i_out_data.cost_value, 0);
                end else begin
                    exp_item = expected_costs.pop_front();
                    if (i_out_data.cost_value !== exp_item.cost_value)
                        report_mismatch("cost_value", i_out_data.cost_value,
                                        exp_item.cost_value);
                    if (i_out_data.outside_image !== exp_item.outside_image)
                        report_mismatch("outside_image", i_out_data.outside_image,
                                        exp_item.outside_image);
                    if (i_out_data.board_mean !== exp_item.board_mean)
                        report_mismatch("board_mean", i_out_data.board_mean,
                                        exp_item.board_mean);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_in_data.func) begin
                    mask_words[i_in_data.mask_address] = i_in_data.mask_value;
                end else begin
                    landed = project_cost(i_in_data, word);
                    cost   = landed ? {2'b00, word} : dpmc_pkg::OUTSIDE_COST;
                    if (!cfg_shadow[dpmc_pkg::CFG_GEOM][32]) begin
                        exp_item.cost_value    = cost;
                        exp_item.outside_image = !landed;
                        exp_item.board_mean    = 1'b0;
                        expected_costs = {expected_costs, exp_item};
                    end else begin
                        if (board_points < BOARD_LIMIT) begin
                            board_total  += cost;
                            board_points += 1;
                        end
                        if (!landed) board_missed = 1;
                        if (i_in_data.board_last) begin
                            exp_item.cost_value    = (board_points != 0) ?
                                                     18'(board_total / board_points) : '0;
                            exp_item.outside_image = board_missed;
                            exp_item.board_mean    = 1'b1;
                            expected_costs = {expected_costs, exp_item};
                            board_total  = 0;
                            board_points = 0;
                            board_missed = 0;
                        end
                    end
                end
            end
        end
        o_pending = expected_costs.size();
    end
endmodule

// ===== verif/tb_top.sv =====
// testbench top: clock, reset, register setup, item stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
    localparam int CYCLE_LIMIT = 2000000;
    // a point that ends with no result can still be in flight; this waits it out
    localparam int SETTLE      = 150;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    dpmc_pkg::t_in_item            i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    dpmc_pkg::t_out_item           o_out_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dpmc_pkg::APB_AW-1:0]   paddr;
    logic [dpmc_pkg::APB_DW-1:0]   pwdata;
    logic [dpmc_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    int fail_count;
    int pending;
    int points_sent;
    int writes_sent;
    int settings_used;
    int cycles;
    int stall_left;
    bit idle_on;

    distorted_projection_mask_cost_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dpmc_cost_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on total run length
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("distorted_projection_mask_cost_core regression: fail");
                $finish;
            end
        end
    end

    // result side: random stall bursts while idling is on
    initial stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // three signed 21-bit subfields packed low to high
    function automatic logic [63:0] pack3(input int a, input int b, input int c);
        logic [20:0] fa, fb, fc;
        fa = a[20:0];
        fb = b[20:0];
        fc = c[20:0];
        return {1'b0, fc, fb, fa};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a setup phase and an access phase, then an idle phase; pready is tied high in the block
    task automatic write_reg(input dpmc_pkg::t_cfg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [63:0] rx, ry, rz, tr, rad, tang, intr, geom);
        write_reg(dpmc_pkg::CFG_ROT_X, rx);
        write_reg(dpmc_pkg::CFG_ROT_Y, ry);
        write_reg(dpmc_pkg::CFG_ROT_Z, rz);
        write_reg(dpmc_pkg::CFG_TRANS, tr);
        write_reg(dpmc_pkg::CFG_RADIAL, rad);
        write_reg(dpmc_pkg::CFG_TANG, tang);
        write_reg(dpmc_pkg::CFG_INTR, intr);
        write_reg(dpmc_pkg::CFG_GEOM, geom);
        settings_used++;
    endtask

    // hold valid with a fixed payload until the item is taken
    task automatic send_item(input dpmc_pkg::t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.func) points_sent++;
        else writes_sent++;
    endtask

    task automatic send_write(input int addr, input int value);
        dpmc_pkg::t_in_item it;
        it              = '0;
        it.mask_address = addr[17:0];
        it.mask_value   = value[15:0];
        send_item(it);
    endtask

    // point at (x, y, z) given in units of 1/65536 m
    task automatic send_point(input int x, input int y, input int z, input bit last);
        dpmc_pkg::t_in_item it;
        it            = '0;
        it.func       = 1'b1;
        it.point_x    = x;
        it.point_y    = y;
        it.point_z    = z;
        it.board_last = last;
        send_item(it);
    endtask

    // mostly points in front of the camera within the field of view, some noise and mask writes
    task automatic send_random(input int count);
        dpmc_pkg::t_in_item it;
        logic [159:0]       noise;
        int z;
        repeat (count) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(dpmc_pkg::t_in_item)-1:0];
            it.func       = 1'b1;
            it.board_last = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0: it.func = 1'b0;
                1, 2: ;
                default: begin
                    z = $urandom_range(65536, 262144);
                    it.point_z = z;
                    it.point_x = int'($urandom_range(0, 2 * z)) - z;
                    it.point_y = int'($urandom_range(0, 2 * z)) - z;
                end
            endcase
            send_item(it);
        end
    endtask

    // no item in flight and every expected result delivered
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] rot_x, rot_y, rot_z, radial, tang, intr_small;
        rot_x = pack3(524288, 0, 0);
        rot_y = pack3(0, 524288, 0);
        rot_z = pack3(0, 0, 524288);
        // mild barrel distortion and a touch of tangential skew
        radial     = pack3(-6554, 655, 0);
        tang       = pack3(66, -40, 0);
        // 16x16 image, focal length and center at 8 px
        intr_small = {16'd128, 16'd128, 16'd128, 16'd128};

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        points_sent   = 0;
        writes_sent   = 0;
        settings_used = 0;
        idle_on       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every word any setting below can read, without idling
        for (int a = 0; a < 256; a++) send_write(a, $urandom);
        for (int k = 1; k <= 4; k++) send_write(k * 65535, $urandom);
        drain();

        idle_on = 1'b1;
        load_setting(rot_x, rot_y, rot_z, '0, radial, tang, intr_small,
                     64'({1'b0, 16'd16, 16'd16}));

        // directed: mask value extremes, depth cases, range edges
        send_write(0, 16'hFFFF);
        send_write(262143, 0);
        send_write(262143, 16'hFFFF);
        send_write(136, 0);
        send_point(0, 0, 65536, 1'b0);                       // image center
        send_point(0, 0, 0, 1'b1);                           // zero depth
        send_point(65536, 65536, -65536, 1'b0);              // behind the camera
        send_point(0, 0, 32'h8000_0000, 1'b0);               // most negative depth
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 0, 65536, 1'b0);           // normalized far beyond 8
        send_point(8 * 65536, 0, 65536, 1'b0);               // normalized exactly 8
        send_point(8 * 65536 - 1, 0, 65536, 1'b0);           // just below 8
        send_point(-64880, -64880, 65536, 1'b0);             // top-left corner
        send_point(62000, 62000, 65536, 1'b0);               // bottom-right corner
        send_point(80000, 0, 65536, 1'b0);                   // just off the right edge
        send_point(0, -80000, 65536, 1'b0);                  // above the image
        send_point(1000, -2000, 32'h7FFF_FFFF, 1'b1);        // far away
        send_random(70);
        drain();

        // same setting, board averages
        write_reg(dpmc_pkg::CFG_GEOM, 64'({1'b1, 16'd16, 16'd16}));
        send_random(80);
        send_point(0, 0, 65536, 1'b1);
        drain();

        // random pose, coefficients and intrinsics on a 16x16 image
        load_setting(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                     64'({1'b0, 16'd16, 16'd16}));
        send_random(50);
        drain();

        // widest geometry on a single row: some columns beyond the store
        load_setting(rot_x, rot_y, rot_z, pack3(1024, -1024, 512), radial, tang,
                     {16'd0, 16'd48, 16'd0, 16'd48}, 64'({1'b1, 16'hFFFF, 16'hFFFF}));
        send_random(60);
        send_point(0, 0, 65536, 1'b1);
        drain();

        // zero width, then zero height: everything lands outside
        load_setting('0, '0, rot_z, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'({1'b0, 16'hFFFF, 16'd0}));
        send_random(25);
        drain();
        write_reg(dpmc_pkg::CFG_GEOM, 64'({1'b1, 16'd0, 16'hFFFF}));
        send_random(25);
        send_point(0, 0, 65536, 1'b1);
        drain();

        // one-row strip, then one-column strip, with extreme coefficients
        load_setting(rot_x, rot_y, rot_z, '0, {1'b0, {63{1'b1}}}, pack3(-1048576, 1048575, 0),
                     {16'd0, 16'h7FF0, 16'd0, 16'h7FF0}, 64'({1'b0, 16'd1, 16'd256}));
        send_random(25);
        drain();
        load_setting(rot_x, rot_y, rot_z, '0, pack3(1048575, -1048576, 1048575), tang,
                     {16'h7FF0, 16'd0, 16'h7FF0, 16'd0}, 64'({1'b0, 16'd256, 16'd1}));
        send_random(25);
        drain();

        // closing stretch with no idling on either side
        idle_on = 1'b0;
        load_setting(rot_x, rot_y, rot_z, '0, radial, tang, intr_small,
                     64'({1'b1, 16'd16, 16'd16}));
        send_random(50);
        send_point(0, 0, 65536, 1'b1);
        drain();
        write_reg(dpmc_pkg::CFG_GEOM, 64'({1'b0, 16'd16, 16'd16}));
        send_random(40);
        drain();

        $display("run covered %0d points and %0d mask writes over %0d register settings",
                 points_sent, writes_sent, settings_used);
        $display("per-point and board-mean modes, zero and full-width geometry, random pose");
        if (fail_count == 0 && pending == 0) begin
            $display("distorted_projection_mask_cost_core regression: pass");
        end else begin
            $display("distorted_projection_mask_cost_core regression: fail");
        end
        $finish;
    end
endmodule

// ===== distorted_projection_mask_cost_core.f =====
design/dpmc_pkg.sv
design/dpmc_cfg.sv
design/dpmc_mul.sv
design/dpmc_div.sv
design/dpmc_mem.sv
design/distorted_projection_mask_cost_core.sv
verif/dpmc_cost_checker.sv
verif/tb_top.sv
